FILE: rtl/core/rv32im_execute_core_macros.svh
// assertion macros for the rv32im execute core
// used by rv32_back, no other dependencies
`ifndef RV32IM_EXECUTE_CORE_MACROS_SVH
`define RV32IM_EXECUTE_CORE_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif
`endif

FILE: rtl/core/rv32_pkg.sv
// shared types and constants for the rv32im execute core
// no dependencies
`timescale 1ns / 1ps
package rv32_pkg;
   localparam logic [31:0] RESET_PC = 32'h8000_0000;
   localparam logic [31:0] RESET_SP = 32'h8000_0400;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [6:0] OP_LUI = 7'h37, OP_AUIPC = 7'h17, OP_JAL = 7'h6f, OP_JALR = 7'h67,
      OP_BRANCH = 7'h63, OP_LOAD = 7'h03, OP_STORE = 7'h23, OP_IMM = 7'h13, OP_REG = 7'h33,
      OP_SYSTEM = 7'h73;
   localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
   localparam logic [2:0] KIND_NONE = 3'd0, KIND_LB = 3'd1, KIND_LH = 3'd2, KIND_LW = 3'd3,
      KIND_LBU = 3'd4, KIND_LHU = 3'd5;
   typedef struct packed {
      logic        is_data;
      logic [31:0] instruction;
      logic [31:0] read_data;
   } item_type;
endpackage

FILE: rtl/core/rv32_front.sv
// front end: accepts requests and holds them in a short queue
// depends on rv32_pkg
`timescale 1ns / 1ps
module rv32_front #(
   parameter int DEPTH = rv32_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [31:0]        req_instruction,
   input  logic [31:0]        req_read_data,
   output logic               q_valid,
   input  logic               q_take,
   output rv32_pkg::item_type q_item
);
   import rv32_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   item_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic push, pop;
   assign req_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_take;
   assign q_item = mem_ff[rp_ff];
   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      if (pop) rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= '{req_opcode, req_instruction, req_read_data};
   end
endmodule

FILE: rtl/core/rv32_divider.sv
// radix-2 unsigned divider, one quotient bit per cycle
// depends on nothing else
`timescale 1ns / 1ps
module rv32_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial, shifted;
   assign shifted = {r_ff, q_ff[31]};
   assign trial = shifted - {1'b0, d_ff};
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = shifted[31:0];
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
   end
   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

FILE: rtl/core/rv32_back.sv
// back end: register file, pc and execution of queued items
// depends on rv32_pkg, rv32_divider and rv32im_execute_core_macros.svh
`timescale 1ns / 1ps
module rv32_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_take,
   input  rv32_pkg::item_type q_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_next_pc,
   output logic               rsp_mem_valid,
   output logic               rsp_mem_write,
   output logic [31:0]        rsp_mem_addr,
   output logic [1:0]         rsp_access_size,
   output logic [31:0]        rsp_store_data,
   output logic               rsp_halted,
   output logic [31:0]        rsp_halt_code
);
   import rv32_pkg::*;
   `include "rv32im_execute_core_macros.svh"
   localparam logic [1:0] ST_RUN = 2'd0, ST_MUL = 2'd1, ST_DIV = 2'd2, ST_WAIT = 2'd3;
   logic [31:0] rf_ff [32];
   logic [31:0] pc_ff, pc_in, hv_ff, hv_in;
   logic [4:0] pd_ff, pd_in;
   logic [2:0] pk_ff, pk_in;
   logic hf_ff, hf_in;
   logic [1:0] st_ff, st_in;
   logic ov_ff, ov_in;
   logic [31:0] o_pc_ff, o_pc_in, o_addr_ff, o_addr_in, o_sd_ff, o_sd_in;
   logic o_mv_ff, o_mv_in, o_mw_ff, o_mw_in;
   logic [1:0] o_sz_ff, o_sz_in;
   // multi-cycle op context
   logic [31:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [4:0] mrd_ff, mrd_in;
   logic [2:0] mf3_ff, mf3_in;
   logic [63:0] prod_ff;
   logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, npc, wval, ua, ub;
   logic [6:0] op;
   logic [4:0] rd, sh, wrd;
   logic [2:0] f3;
   logic [6:0] f7;
   logic we, fire, out_free, div_start, div_done;
   logic [31:0] quo, rem, dres, mres;
   assign ins = q_item.instruction;
   assign op = ins[6:0];
   assign rd = ins[11:7];
   assign f3 = ins[14:12];
   assign f7 = ins[31:25];
   assign sh = ins[24:20];
   assign a = (ins[19:15] == 5'd0) ? '0 : rf_ff[ins[19:15]];
   assign b = (ins[24:20] == 5'd0) ? '0 : rf_ff[ins[24:20]];
   assign imm_i = {{20{ins[31]}}, ins[31:20]};
   assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
   assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
   assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
   assign out_free = !ov_ff || !rsp_stall;
   assign fire = (st_ff == ST_RUN) && q_valid && out_free;
   assign q_take = fire;
   // divider sees magnitudes for signed ops
   assign ua = (!mf3_ff[0] && ma_ff[31]) ? -ma_ff : ma_ff;
   assign ub = (!mf3_ff[0] && mb_ff[31]) ? -mb_ff : mb_ff;
   assign div_start = fire && !q_item.is_data && !hf_ff && op == OP_REG && f7 == 7'd1
      && f3[2];
   rv32_divider u_div (
      .clock(clock), .reset(reset), .start(st_ff == ST_WAIT), .dividend(ua), .divisor(ub),
      .done(div_done), .quotient(quo), .remainder(rem)
   );
   always_comb begin
      dres = '0;
      if (mb_ff == '0) dres = mf3_ff[1] ? ma_ff : '1;
      else if (!mf3_ff[0] && ma_ff == 32'h8000_0000 && mb_ff == '1)
         dres = mf3_ff[1] ? '0 : 32'h8000_0000;
      else if (mf3_ff[0]) dres = mf3_ff[1] ? rem : quo;
      else if (mf3_ff[1]) dres = ma_ff[31] ? -rem : rem;
      else dres = (ma_ff[31] != mb_ff[31]) ? -quo : quo;
      unique case (mf3_ff[1:0])
         2'd0: mres = prod_ff[31:0];
         2'd1: mres = prod_ff[63:32] - (ma_ff[31] ? mb_ff : '0) - (mb_ff[31] ? ma_ff : '0);
         2'd2: mres = prod_ff[63:32] - (ma_ff[31] ? mb_ff : '0);
         default: mres = prod_ff[63:32];
      endcase
   end
   always_comb begin
      pc_in = pc_ff; hv_in = hv_ff; pd_in = pd_ff; pk_in = pk_ff; hf_in = hf_ff;
      st_in = st_ff; ma_in = ma_ff; mb_in = mb_ff; mrd_in = mrd_ff; mf3_in = mf3_ff;
      ov_in = ov_ff && rsp_stall;
      o_pc_in = o_pc_ff; o_mv_in = o_mv_ff; o_mw_in = o_mw_ff; o_addr_in = o_addr_ff;
      o_sz_in = o_sz_ff; o_sd_in = o_sd_ff;
      we = 1'b0; wrd = rd; wval = '0; npc = pc_ff + 32'd4;
      unique case (st_ff)
         ST_MUL: begin
            we = 1'b1; wrd = mrd_ff; wval = mres; st_in = ST_RUN;
         end
         ST_WAIT: st_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               we = 1'b1; wrd = mrd_ff; wval = dres; st_in = ST_RUN;
            end
         end
         default: begin
            if (fire) begin
               ov_in = 1'b1;
               o_mv_in = 1'b0; o_mw_in = 1'b0; o_addr_in = '0; o_sz_in = '0; o_sd_in = '0;
               if (q_item.is_data) begin
                  wrd = pd_ff;
                  we = pk_ff != KIND_NONE;
                  unique case (pk_ff)
                     KIND_LB: wval = {{24{q_item.read_data[7]}}, q_item.read_data[7:0]};
                     KIND_LH: wval = {{16{q_item.read_data[15]}}, q_item.read_data[15:0]};
                     KIND_LBU: wval = {24'd0, q_item.read_data[7:0]};
                     KIND_LHU: wval = {16'd0, q_item.read_data[15:0]};
                     default: wval = q_item.read_data;
                  endcase
                  pk_in = KIND_NONE; pd_in = '0;
               end else if (!hf_ff) begin
                  pk_in = KIND_NONE; pd_in = '0;
                  unique case (op)
                     OP_LUI: begin we = 1'b1; wval = {ins[31:12], 12'd0}; end
                     OP_AUIPC: begin we = 1'b1; wval = pc_ff + {ins[31:12], 12'd0}; end
                     OP_JAL: begin we = 1'b1; wval = pc_ff + 32'd4; npc = pc_ff + imm_j; end
                     OP_JALR: begin
                        if (f3 == 3'd0) begin
                           we = 1'b1; wval = pc_ff + 32'd4; npc = (a + imm_i) & ~32'd1;
                        end
                     end
                     OP_BRANCH: begin
                        case (f3)
                           3'd0: if (a == b) npc = pc_ff + imm_b;
                           3'd1: if (a != b) npc = pc_ff + imm_b;
                           3'd4: if ($signed(a) < $signed(b)) npc = pc_ff + imm_b;
                           3'd5: if ($signed(a) >= $signed(b)) npc = pc_ff + imm_b;
                           3'd6: if (a < b) npc = pc_ff + imm_b;
                           3'd7: if (a >= b) npc = pc_ff + imm_b;
                           default: ;
                        endcase
                     end
                     OP_LOAD: begin
                        if (f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7) begin
                           o_mv_in = 1'b1; o_addr_in = a + imm_i; o_sz_in = f3[1:0];
                           pd_in = rd;
                           case (f3)
                              3'd0: pk_in = KIND_LB;
                              3'd1: pk_in = KIND_LH;
                              3'd2: pk_in = KIND_LW;
                              3'd4: pk_in = KIND_LBU;
                              default: pk_in = KIND_LHU;
                           endcase
                        end
                     end
                     OP_STORE: begin
                        if (f3 <= 3'd2) begin
                           o_mv_in = 1'b1; o_mw_in = 1'b1; o_addr_in = a + imm_s;
                           o_sz_in = f3[1:0]; o_sd_in = b;
                        end
                     end
                     OP_IMM: begin
                        we = 1'b1;
                        case (f3)
                           3'd0: wval = a + imm_i;
                           3'd2: wval = {31'd0, $signed(a) < $signed(imm_i)};
                           3'd3: wval = {31'd0, a < imm_i};
                           3'd4: wval = a ^ imm_i;
                           3'd6: wval = a | imm_i;
                           3'd7: wval = a & imm_i;
                           3'd1: begin we = f7 == 7'd0; wval = a << sh; end
                           default: begin
                              we = f7 == 7'd0 || f7 == 7'h20;
                              wval = (f7 == 7'h20) ? 32'($signed(a) >>> sh) : a >> sh;
                           end
                        endcase
                     end
                     OP_REG: begin
                        if (f7 == 7'd0) begin
                           we = 1'b1;
                           case (f3)
                              3'd0: wval = a + b;
                              3'd1: wval = a << b[4:0];
                              3'd2: wval = {31'd0, $signed(a) < $signed(b)};
                              3'd3: wval = {31'd0, a < b};
                              3'd4: wval = a ^ b;
                              3'd5: wval = a >> b[4:0];
                              3'd6: wval = a | b;
                              default: wval = a & b;
                           endcase
                        end else if (f7 == 7'h20) begin
                           we = f3 == 3'd0 || f3 == 3'd5;
                           wval = (f3 == 3'd0) ? a - b : 32'($signed(a) >>> b[4:0]);
                        end else if (f7 == 7'd1) begin
                           ma_in = a; mb_in = b; mrd_in = rd; mf3_in = f3;
                           st_in = f3[2] ? ST_WAIT : ST_MUL;
                        end
                     end
                     OP_SYSTEM: begin
                        if (ins == INSN_EBREAK) begin
                           hf_in = 1'b1; hv_in = rf_ff[10];
                        end
                     end
                     default: ;
                  endcase
                  pc_in = npc;
               end
               o_pc_in = pc_in;
            end
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= RESET_PC; hv_ff <= '0; pd_ff <= '0; pk_ff <= KIND_NONE; hf_ff <= 1'b0;
         st_ff <= ST_RUN; ov_ff <= 1'b0;
         for (int i = 0; i < 32; i++) rf_ff[i] <= (i == 2) ? RESET_SP : '0;
      end else begin
         pc_ff <= pc_in; hv_ff <= hv_in; pd_ff <= pd_in; pk_ff <= pk_in; hf_ff <= hf_in;
         st_ff <= st_in; ov_ff <= ov_in;
         if (we && wrd != 5'd0) rf_ff[wrd] <= wval;
      end
      ma_ff <= ma_in; mb_ff <= mb_in; mrd_ff <= mrd_in; mf3_ff <= mf3_in;
      prod_ff <= {32'd0, ma_in} * {32'd0, mb_in};
      o_pc_ff <= o_pc_in; o_mv_ff <= o_mv_in; o_mw_ff <= o_mw_in; o_addr_ff <= o_addr_in;
      o_sz_ff <= o_sz_in; o_sd_ff <= o_sd_in;
   end
   assign rsp_valid = ov_ff;
   assign rsp_next_pc = o_pc_ff;
   assign rsp_mem_valid = o_mv_ff;
   assign rsp_mem_write = o_mw_ff;
   assign rsp_mem_addr = o_addr_ff;
   assign rsp_access_size = o_sz_ff;
   assign rsp_store_data = o_sd_ff;
   assign rsp_halted = hf_ff;
   assign rsp_halt_code = hv_ff;
   `ASSERT_IMPL(a_x0_zero, clock, reset, rf_ff[0] == '0)
   `ASSERT_NEXT(a_halt_sticky, clock, reset, hf_ff, hf_ff)
   `ASSERT_IMPL(a_no_take_busy, clock, reset, !(q_take && st_ff != ST_RUN))
   `ASSERT_NEXT(a_div_start, clock, reset, div_start, st_ff == ST_WAIT)
endmodule

FILE: rtl/core/rv32im_execute_core.sv
// Single-issue RV32IM execute core. Requests carry either an instruction word (opcode 0) or
// returning load data (opcode 1) and each gives exactly one response with the next pc, any
// memory request and the halt status. mul/mulh* use a registered 32x32 multiplier and
// div/rem the radix-2 divider (one quotient bit per cycle); the back end takes no new item
// until they finish. A two-entry request queue and the response register let both sides
// stall on their own. Depends on rv32_pkg, rv32_front, rv32_back.
`timescale 1ns / 1ps
module rv32im_execute_core #(
   parameter int QDEPTH = rv32_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_read_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_mem_valid,
   output logic        rsp_mem_write,
   output logic [31:0] rsp_mem_addr,
   output logic [1:0]  rsp_access_size,
   output logic [31:0] rsp_store_data,
   output logic        rsp_halted,
   output logic [31:0] rsp_halt_code
);
   import rv32_pkg::*;
   logic q_valid, q_take;
   item_type q_item;
   rv32_front #(.DEPTH(QDEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_instruction, .req_read_data,
      .q_valid, .q_take, .q_item
   );
   rv32_back u_back (
      .clock, .reset, .q_valid, .q_take, .q_item, .rsp_valid, .rsp_stall, .rsp_next_pc,
      .rsp_mem_valid, .rsp_mem_write, .rsp_mem_addr, .rsp_access_size, .rsp_store_data,
      .rsp_halted, .rsp_halt_code
   );
endmodule

FILE: bench/tb.sv
// self-checking bench for rv32im_execute_core: directed and random requests, scoreboard check
// depends on rv32_pkg and the rtl of rv32im_execute_core
`timescale 1ns / 1ps
module tb;
   import rv32_pkg::*;

   localparam logic OPC_INSN = 1'b0, OPC_DATA = 1'b1;
   localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3,
      F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
   localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5,
      F3_BLTU = 3'd6, F3_BGEU = 3'd7;
   localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2, F3_MULHU = 3'd3,
      F3_DIV = 3'd4, F3_DIVU = 3'd5, F3_REM = 3'd6, F3_REMU = 3'd7;
   localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2, F3_LBU = 3'd4,
      F3_LHU = 3'd5;
   localparam logic [2:0] F3_SB = 3'd0, F3_SW = 3'd2;
   localparam logic [6:0] F7_BASE = 7'h00, F7_ALT = 7'h20, F7_MULDIV = 7'h01;
   localparam logic [4:0] REG_A0 = 5'd10;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        mem_valid;
      logic        mem_write;
      logic [31:0] mem_addr;
      logic [1:0]  access_size;
      logic [31:0] store_data;
      logic        halted;
      logic [31:0] halt_code;
   } rsp_type;

   class core_scoreboard;
      logic [31:0] regs [32];
      logic [31:0] pc;
      logic [4:0]  pend_dest;
      logic [2:0]  pend_kind;
      logic        halt;
      logic [31:0] halt_val;
      rsp_type     exp_q [$];
      int          errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         regs[2] = RESET_SP;
         pc = RESET_PC;
         pend_dest = '0;
         pend_kind = KIND_NONE;
         halt = 1'b0;
         halt_val = '0;
         errors = 0;
      endfunction

      function void wr(logic [4:0] rd, logic [31:0] v);
         if (rd != 5'd0) regs[rd] = v;
      endfunction

      function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit want_rem);
         logic signed [31:0] sa, sb;
         sa = a;
         sb = b;
         if (b == 32'd0) return want_rem ? a : 32'hffff_ffff;
         if (a == 32'h8000_0000 && b == 32'hffff_ffff) return want_rem ? 32'd0 : a;
         return want_rem ? sa % sb : sa / sb;
      endfunction

      // executes one request against the shadow state and queues its response
      function void note(logic opc, logic [31:0] ins, logic [31:0] rdata);
         rsp_type r;
         logic [31:0] a, b, npc, imm_i, imm_s, imm_b, imm_j, v;
         logic [63:0] ea, eb, ua, ub;
         logic [6:0] op, f7;
         logic [4:0] rd, sh;
         logic [2:0] f3;
         bit t;
         r = '0;
         if (opc == OPC_DATA) begin
            case (pend_kind)
               KIND_LB:  wr(pend_dest, {{24{rdata[7]}}, rdata[7:0]});
               KIND_LH:  wr(pend_dest, {{16{rdata[15]}}, rdata[15:0]});
               KIND_LW:  wr(pend_dest, rdata);
               KIND_LBU: wr(pend_dest, {24'd0, rdata[7:0]});
               KIND_LHU: wr(pend_dest, {16'd0, rdata[15:0]});
               default: ;
            endcase
            pend_kind = KIND_NONE;
            pend_dest = '0;
         end else if (!halt) begin
            op = ins[6:0];
            rd = ins[11:7];
            f3 = ins[14:12];
            f7 = ins[31:25];
            sh = ins[24:20];
            a = regs[ins[19:15]];
            b = regs[ins[24:20]];
            npc = pc + 32'd4;
            imm_i = {{20{ins[31]}}, ins[31:20]};
            imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            pend_kind = KIND_NONE;
            pend_dest = '0;
            case (op)
               OP_LUI:   wr(rd, {ins[31:12], 12'd0});
               OP_AUIPC: wr(rd, pc + {ins[31:12], 12'd0});
               OP_JAL: begin
                  wr(rd, pc + 32'd4);
                  npc = pc + imm_j;
               end
               OP_JALR: if (f3 == 3'd0) begin
                  npc = (a + imm_i) & ~32'd1;
                  wr(rd, pc + 32'd4);
               end
               OP_BRANCH: begin
                  case (f3)
                     F3_BEQ:  t = a == b;
                     F3_BNE:  t = a != b;
                     F3_BLT:  t = $signed(a) < $signed(b);
                     F3_BGE:  t = $signed(a) >= $signed(b);
                     F3_BLTU: t = a < b;
                     F3_BGEU: t = a >= b;
                     default: t = 0;
                  endcase
                  if (t) npc = pc + imm_b;
               end
               OP_LOAD: begin
                  case (f3)
                     F3_LB:  pend_kind = KIND_LB;
                     F3_LH:  pend_kind = KIND_LH;
                     F3_LW:  pend_kind = KIND_LW;
                     F3_LBU: pend_kind = KIND_LBU;
                     F3_LHU: pend_kind = KIND_LHU;
                     default: ;
                  endcase
                  if (pend_kind != KIND_NONE) begin
                     r.mem_valid = 1'b1;
                     r.mem_addr = a + imm_i;
                     r.access_size = f3[1:0];
                     pend_dest = rd;
                  end
               end
               OP_STORE: if (f3 <= F3_SW) begin
                  r.mem_valid = 1'b1;
                  r.mem_write = 1'b1;
                  r.mem_addr = a + imm_s;
                  r.access_size = f3[1:0];
                  r.store_data = b;
               end
               OP_IMM: case (f3)
                  F3_ADD:  wr(rd, a + imm_i);
                  F3_SLT:  wr(rd, {31'd0, $signed(a) < $signed(imm_i)});
                  F3_SLTU: wr(rd, {31'd0, a < imm_i});
                  F3_XOR:  wr(rd, a ^ imm_i);
                  F3_OR:   wr(rd, a | imm_i);
                  F3_AND:  wr(rd, a & imm_i);
                  F3_SLL:  if (f7 == F7_BASE) wr(rd, a << sh);
                  default: begin
                     if (f7 == F7_BASE) wr(rd, a >> sh);
                     else if (f7 == F7_ALT) wr(rd, $signed(a) >>> sh);
                  end
               endcase
               OP_REG: begin
                  if (f7 == F7_BASE) begin
                     case (f3)
                        F3_ADD:  wr(rd, a + b);
                        F3_SLL:  wr(rd, a << b[4:0]);
                        F3_SLT:  wr(rd, {31'd0, $signed(a) < $signed(b)});
                        F3_SLTU: wr(rd, {31'd0, a < b});
                        F3_XOR:  wr(rd, a ^ b);
                        F3_SR:   wr(rd, a >> b[4:0]);
                        F3_OR:   wr(rd, a | b);
                        default: wr(rd, a & b);
                     endcase
                  end else if (f7 == F7_ALT) begin
                     if (f3 == F3_ADD) wr(rd, a - b);
                     else if (f3 == F3_SR) wr(rd, $signed(a) >>> b[4:0]);
                  end else if (f7 == F7_MULDIV) begin
                     ea = {{32{a[31]}}, a};
                     eb = {{32{b[31]}}, b};
                     ua = {32'd0, a};
                     ub = {32'd0, b};
                     case (f3)
                        F3_MUL:    v = a * b;
                        F3_MULH:   v = 32'((ea * eb) >> 32);
                        F3_MULHSU: v = 32'((ea * ub) >> 32);
                        F3_MULHU:  v = 32'((ua * ub) >> 32);
                        F3_DIV:    v = sdiv(a, b, 0);
                        F3_DIVU:   v = (b == 0) ? 32'hffff_ffff : a / b;
                        F3_REM:    v = sdiv(a, b, 1);
                        default:   v = (b == 0) ? a : a % b;
                     endcase
                     wr(rd, v);
                  end
               end
               OP_SYSTEM: if (ins == INSN_EBREAK) begin
                  halt = 1'b1;
                  halt_val = regs[REG_A0];
               end
               default: ;
            endcase
            pc = npc;
         end
         r.next_pc = pc;
         r.halted = halt;
         r.halt_code = halt_val;
         exp_q.push_back(r);
      endfunction

      function void check(rsp_type act);
         rsp_type e;
         if (exp_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response pc %h", act.next_pc);
            return;
         end
         e = exp_q.pop_front();
         if (e.next_pc !== act.next_pc || e.mem_valid !== act.mem_valid ||
             e.mem_write !== act.mem_write || e.mem_addr !== act.mem_addr ||
             e.access_size !== act.access_size || e.store_data !== act.store_data ||
             e.halted !== act.halted || e.halt_code !== act.halt_code) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp pc %h mv %b mw %b addr %h sz %d sd %h h %b hc %h",
                  e.next_pc, e.mem_valid, e.mem_write, e.mem_addr, e.access_size,
                  e.store_data, e.halted, e.halt_code);
               $display("         act pc %h mv %b mw %b addr %h sz %d sd %h h %b hc %h",
                  act.next_pc, act.mem_valid, act.mem_write, act.mem_addr,
                  act.access_size, act.store_data, act.halted, act.halt_code);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OPC_INSN;
   logic [31:0] req_instruction = '0;
   logic [31:0] req_read_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_next_pc, rsp_mem_addr, rsp_store_data, rsp_halt_code;
   logic        rsp_mem_valid, rsp_mem_write, rsp_halted;
   logic [1:0]  rsp_access_size;

   core_scoreboard sb = new();
   bit quiet = 0;
   bit load_open = 0;

   rv32im_execute_core uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // response side: random stall per response, checked at the accepting edge
   initial begin
      int wait_left;
      bit take;
      rsp_type act;
      wait_left = 0;
      forever begin
         @(negedge clock);
         rsp_stall <= (wait_left > 0 && !quiet);
         if (wait_left > 0) wait_left--;
         #1;
         take = rsp_valid && !rsp_stall && !reset;
         act = {rsp_next_pc, rsp_mem_valid, rsp_mem_write, rsp_mem_addr, rsp_access_size,
                rsp_store_data, rsp_halted, rsp_halt_code};
         @(posedge clock);
         if (take) begin
            sb.check(act);
            wait_left = $urandom_range(0, 8);
         end
      end
   end

   task automatic send(logic opc, logic [31:0] ins, logic [31:0] rdata);
      int gap;
      bit ok;
      gap = quiet ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= opc;
      req_instruction <= ins;
      req_read_data <= rdata;
      ok = 0;
      while (!ok) begin
         #1;
         ok = !req_stall;
         @(posedge clock);
         if (!ok) @(negedge clock);
      end
      sb.note(opc, ins, rdata);
      if (opc == OPC_DATA) load_open = 0;
      else if (ins[6:0] == OP_LOAD && ins[14:12] != 3'd3 && ins[14:12] < 3'd6) load_open = 1;
      else load_open = 0;
   endtask

   task automatic exec(logic [31:0] ins);
      send(OPC_INSN, ins, $urandom);
   endtask

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   // random word, usually with a forced major opcode and mostly well-formed fields
   function automatic logic [31:0] rand_insn();
      logic [31:0] ins;
      int pick;
      ins = $urandom;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) begin
         ins[11:7] = 5'($urandom_range(0, 7));
         ins[19:15] = 5'($urandom_range(0, 7));
         ins[24:20] = 5'($urandom_range(0, 7));
      end
      if (pick < 8) ins[6:0] = OP_LUI;
      else if (pick < 11) ins[6:0] = OP_AUIPC;
      else if (pick < 15) ins[6:0] = OP_JAL;
      else if (pick < 19) begin
         ins[6:0] = OP_JALR;
         if ($urandom_range(0, 4) != 0) ins[14:12] = 3'd0;
      end else if (pick < 27) ins[6:0] = OP_BRANCH;
      else if (pick < 38) begin
         ins[6:0] = OP_LOAD;
         if ($urandom_range(0, 7) != 0)
            case ($urandom_range(0, 4))
               0: ins[14:12] = F3_LB;
               1: ins[14:12] = F3_LH;
               2: ins[14:12] = F3_LW;
               3: ins[14:12] = F3_LBU;
               default: ins[14:12] = F3_LHU;
            endcase
      end else if (pick < 46) begin
         ins[6:0] = OP_STORE;
         if ($urandom_range(0, 7) != 0) ins[14:12] = 3'($urandom_range(F3_SB, F3_SW));
      end else if (pick < 66) begin
         ins[6:0] = OP_IMM;
         if (ins[14:12] == F3_SLL || ins[14:12] == F3_SR)
            case ($urandom_range(0, 4))
               0, 1: ins[31:25] = F7_BASE;
               2, 3: ins[31:25] = F7_ALT;
               default: ;
            endcase
      end else if (pick < 93) begin
         ins[6:0] = OP_REG;
         case ($urandom_range(0, 6))
            0, 1: ins[31:25] = F7_BASE;
            2: ins[31:25] = F7_ALT;
            3, 4, 5: ins[31:25] = F7_MULDIV;
            default: ;
         endcase
      end else if (pick < 96) ins[6:0] = OP_SYSTEM;
      if (ins == INSN_EBREAK) ins[31] = 1'b1;
      return ins;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // overflow, division by zero, high multiplies, arithmetic shifts
      exec({20'h80000, 5'd5, OP_LUI});
      exec(enc_i(12'hfff, 5'd0, F3_ADD, 5'd6, OP_IMM));
      exec(enc_r(F7_MULDIV, 5'd6, 5'd5, F3_DIV, 5'd7, OP_REG));
      exec(enc_r(F7_MULDIV, 5'd6, 5'd5, F3_REM, 5'd8, OP_REG));
      exec(enc_r(F7_MULDIV, 5'd0, 5'd5, F3_DIV, 5'd9, OP_REG));
      exec(enc_r(F7_MULDIV, 5'd0, 5'd6, F3_DIVU, 5'd9, OP_REG));
      exec(enc_r(F7_MULDIV, 5'd0, 5'd5, F3_REM, 5'd9, OP_REG));
      exec(enc_r(F7_MULDIV, 5'd0, 5'd6, F3_REMU, 5'd9, OP_REG));
      exec(enc_r(F7_MULDIV, 5'd6, 5'd5, F3_MULH, 5'd11, OP_REG));
      exec(enc_r(F7_MULDIV, 5'd6, 5'd5, F3_MULHSU, 5'd11, OP_REG));
      exec(enc_r(F7_MULDIV, 5'd6, 5'd5, F3_MULHU, 5'd11, OP_REG));
      exec(enc_i({F7_ALT, 5'd31}, 5'd5, F3_SR, 5'd12, OP_IMM));
      exec(enc_r(F7_ALT, 5'd6, 5'd5, F3_SR, 5'd12, OP_REG));
      exec(enc_i({F7_BASE, 5'd31}, 5'd6, F3_SLL, 5'd13, OP_IMM));
      exec(enc_i(12'h7ff, 5'd0, F3_ADD, 5'd14, OP_IMM));
      // sub-word loads, load to x0, stray data, dropped load
      exec(enc_i(12'h000, 5'd2, F3_LB, 5'd15, OP_LOAD));
      send(OPC_DATA, 0, 32'hffff_ff80);
      exec(enc_i(12'h800, 5'd2, F3_LHU, 5'd16, OP_LOAD));
      send(OPC_DATA, 0, 32'hffff_8001);
      exec(enc_i(12'h004, 5'd2, F3_LW, 5'd0, OP_LOAD));
      send(OPC_DATA, 0, 32'hdead_beef);
      send(OPC_DATA, 0, 32'h1234_5678);
      exec(enc_i(12'h008, 5'd2, F3_LH, 5'd17, OP_LOAD));
      exec(enc_i(12'hfff, 5'd5, 3'd0, 5'd1, OP_JALR));
      exec(32'hffff_ffff);

      for (int i = 0; i < 950; i++) begin
         quiet = ((i / 100) % 3) == 1;
         if (i == 475) begin
            // drain: drop valid first so the last request is not taken again
            @(negedge clock);
            req_valid <= 1'b0;
            while (sb.exp_q.size() > 0) @(posedge clock);
         end
         if (load_open && $urandom_range(0, 99) < 85) send(OPC_DATA, 0, $urandom);
         else if ($urandom_range(0, 99) < 4) send(OPC_DATA, 0, $urandom);
         else exec(rand_insn());
      end
      quiet = 0;
      exec(enc_i(12'h5a5, 5'd0, F3_ADD, REG_A0, OP_IMM));
      exec(INSN_EBREAK);
      exec(rand_insn());
      exec(enc_i(12'h000, 5'd2, F3_LW, 5'd3, OP_LOAD));
      send(OPC_DATA, 0, $urandom);
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.exp_q.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.exp_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rv32_pkg.sv
rtl/core/rv32_front.sv
rtl/core/rv32_divider.sv
rtl/core/rv32_back.sv
rtl/core/rv32im_execute_core.sv
bench/tb.sv
